>>> hdl/i2crb_pkg.sv
// ----------------------------------------------------------------------------
// i2crb_pkg
// Shared types and constants for the I2C target register bank.
// ----------------------------------------------------------------------------
package i2crb_pkg;

    localparam int unsigned NUM_REGS_DEF = 16;
    localparam int unsigned PTR_W        = 8;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned CFG_W        = 16;
    localparam int unsigned APB_AW       = 3;
    localparam int unsigned APB_DW       = 32;

    localparam logic [CFG_W-1:0]  TEMP_RESET = 16'd255;
    localparam logic [CFG_W-1:0]  HUM_RESET  = 16'd600;
    localparam logic [DATA_W-1:0] ERR_BYTE   = 8'hFF;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic REG_TEMP = 1'b0;
    localparam logic REG_HUM  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] temp;
        logic [CFG_W-1:0] hum;
    } t_cfg;

endpackage

>>> hdl/i2crb_if.sv
// ----------------------------------------------------------------------------
// i2crb_if
// Request and response channels of the I2C target register bank.
// ----------------------------------------------------------------------------
interface i2crb_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic       first_byte;
    logic [7:0] data_in;

    modport source (output valid, cmd, first_byte, data_in, input ready);
    modport sink   (input valid, cmd, first_byte, data_in, output ready);
endinterface

interface i2crb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       last;
    logic       pointer_error;

    modport source (output valid, read_data, last, pointer_error, input ready);
    modport sink   (input valid, read_data, last, pointer_error, output ready);
endinterface

>>> hdl/i2c_target_register_bank.sv
// ----------------------------------------------------------------------------
// i2c_target_register_bank
// I2C target register bank with auto-incrementing register pointer.
//
// i_req carries one transaction per received byte (cmd = write) or per master
// read request (cmd = read). For a write, a first byte loads the pointer, later
// bytes are stored at the pointer, which then advances; bytes past the end of
// the bank are dropped. A read request sends registers from the pointer to the
// end on o_rsp, one byte per cycle while o_rsp is ready, last set on the final
// byte; registers 0 to 3 return the temperature and humidity values big-endian.
// An out-of-range pointer yields a single 0xFF with pointer_error and last.
// An accepted read loads the address register; each byte then passes the
// stage-1 register and the memory read into the response register. The request
// side is not ready while a burst is being issued. Writes may be accepted while
// earlier bytes drain. When o_rsp stalls, the response register and the one
// in-flight memory read hold and the burst pauses. Reset clears the pointer,
// marks every bank entry as zero and loads the configuration defaults
// (temperature 255, humidity 600); no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_target_register_bank #(
    parameter int unsigned NUM_REGS = i2crb_pkg::NUM_REGS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    i2crb_req_if.sink                    i_req,
    i2crb_rsp_if.source                  o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [i2crb_pkg::APB_AW-1:0] paddr,
    input  logic [i2crb_pkg::APB_DW-1:0] pwdata,
    output logic [i2crb_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import i2crb_pkg::*;

    localparam int unsigned       AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [PTR_W:0]    NREGS  = (PTR_W+1)'(NUM_REGS);
    localparam logic [AW-1:0]     LAST_A = AW'(NUM_REGS - 1);
    localparam logic [PTR_W:0]    CFG_N  = (PTR_W+1)'(4);

    t_cfg              w_cfg;
    t_state            r_state;
    t_state            n_state;
    logic [PTR_W-1:0]  r_ptr;
    logic [AW-1:0]     r_addr;
    logic              r_err;
    logic              r_s1_pend;
    logic [AW-1:0]     r_s1_addr;
    logic              r_s1_last;
    logic              r_s1_err;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              r_out_err;

    logic              w_acc;
    logic              w_in_range;
    logic              w_we;
    logic              w_issue;
    logic              w_s1_move;
    logic              w_last_a;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_cfg_byte;
    logic [DATA_W-1:0] w_s1_data;

    i2crb_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    i2crb_mem #(
        .DEPTH (NUM_REGS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_ptr[AW-1:0]),
        .i_wdata (i_req.data_in),
        .i_re    (w_issue && !r_err),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_acc      = i_req.valid && i_req.ready;
    assign w_in_range = (PTR_W+1)'(r_ptr) < NREGS;
    assign w_we       = w_acc && (i_req.cmd == CMD_WRITE) && !i_req.first_byte
                        && w_in_range;
    assign w_s1_move  = r_s1_pend && (!r_out_valid || o_rsp.ready);
    assign w_last_a   = (r_addr == LAST_A);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_req.cmd == CMD_READ)) begin
                    n_state = ST_BURST;
                end
            end
            ST_BURST: begin
                if (w_issue && (r_err || w_last_a)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        w_issue     = 1'b0;
        unique case (r_state)
            ST_IDLE:  i_req.ready = 1'b1;
            ST_BURST: w_issue = !r_s1_pend || w_s1_move;
            default:  ;
        endcase
    end

    always_comb begin
        unique case (r_s1_addr[1:0])
            2'd0:    w_cfg_byte = w_cfg.temp[15:8];
            2'd1:    w_cfg_byte = w_cfg.temp[7:0];
            2'd2:    w_cfg_byte = w_cfg.hum[15:8];
            default: w_cfg_byte = w_cfg.hum[7:0];
        endcase
    end

    always_comb begin
        priority if (r_s1_err) begin
            w_s1_data = ERR_BYTE;
        end else if ((PTR_W+1)'(r_s1_addr) < CFG_N) begin
            w_s1_data = w_cfg_byte;
        end else begin
            w_s1_data = w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_s1_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc && (i_req.cmd == CMD_WRITE)) begin
                if (i_req.first_byte) begin
                    r_ptr <= i_req.data_in;
                end else if (w_in_range) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (w_issue) begin
                r_s1_pend <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_pend <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req.cmd == CMD_READ)) begin
            r_addr <= r_ptr[AW-1:0];
            r_err  <= !w_in_range;
        end else if (w_issue) begin
            r_addr <= r_addr + 1'b1;
        end
        if (w_issue) begin
            r_s1_addr <= r_addr;
            r_s1_last <= r_err || w_last_a;
            r_s1_err  <= r_err;
        end
        if (w_s1_move) begin
            r_out_data <= w_s1_data;
            r_out_last <= r_s1_last;
            r_out_err  <= r_s1_err;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_out_data;
    assign o_rsp.last          = r_out_last;
    assign o_rsp.pointer_error = r_out_err;

endmodule

>>> hdl/i2crb_mem.sv
// ----------------------------------------------------------------------------
// i2crb_mem
// Register bank storage: one write port, one registered read port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module i2crb_mem #(
    parameter int unsigned DEPTH = i2crb_pkg::NUM_REGS_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [i2crb_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [i2crb_pkg::DATA_W-1:0] o_rdata
);
    import i2crb_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rdata;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

>>> hdl/i2crb_apb.sv
// ----------------------------------------------------------------------------
// i2crb_apb
// APB configuration registers: temperature and humidity values.
// ----------------------------------------------------------------------------
module i2crb_apb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [i2crb_pkg::APB_AW-1:0] paddr,
    input  logic [i2crb_pkg::APB_DW-1:0] pwdata,
    output logic [i2crb_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output i2crb_pkg::t_cfg              o_cfg
);
    import i2crb_pkg::*;

    logic             w_wr;
    logic             w_idx;
    logic [CFG_W-1:0] r_temp;
    logic [CFG_W-1:0] r_hum;

    assign pready = 1'b1;
    assign w_idx  = paddr[2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= TEMP_RESET;
            r_hum  <= HUM_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TEMP: r_temp <= pwdata[CFG_W-1:0];
                REG_HUM:  r_hum  <= pwdata[CFG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TEMP: prdata = {{(APB_DW-CFG_W){1'b0}}, r_temp};
            REG_HUM:  prdata = {{(APB_DW-CFG_W){1'b0}}, r_hum};
            default:  prdata = '0;
        endcase
    end

    assign o_cfg.temp = r_temp;
    assign o_cfg.hum  = r_hum;

endmodule

>>> tb/sv/i2c_target_register_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_target_register_bank_tb
// Self-checking bench for the I2C target register bank: a shadow bank and
// pointer predict every read burst byte, and each response transaction is
// compared with the oldest pending byte. Covers pointer and data writes,
// error bursts, config updates, random traffic and back-pressure.
// ----------------------------------------------------------------------------
module i2c_target_register_bank_tb;
    import i2crb_pkg::*;

    localparam int unsigned NUM_REGS   = NUM_REGS_DEF;
    localparam int          SETTLE     = 12;
    localparam longint      CYCLE_MAX  = 2_000_000;
    localparam logic [APB_AW-1:0] ADDR_TEMP = {REG_TEMP, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_HUM  = {REG_HUM, 2'b00};

    typedef struct packed {
        logic             cmd;
        logic             first_byte;
        logic [DATA_W-1:0] data;
    } t_bus_op;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              err;
    } t_tx_byte;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    i2crb_req_if req_if ();
    i2crb_rsp_if rsp_if ();

    i2c_target_register_bank #(
        .NUM_REGS (NUM_REGS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow state
    logic [DATA_W-1:0] shadow_bank [NUM_REGS];
    logic [PTR_W-1:0]  shadow_ptr;
    logic [CFG_W-1:0]  shadow_temp;
    logic [CFG_W-1:0]  shadow_hum;

    t_tx_byte bytes_due [$];
    int       fail_count;
    longint   cycle_count;
    bit       req_gaps;
    bit       rsp_stalls;
    int       hold_left;
    int       stall_left;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void expect_byte(input t_tx_byte b);
        bytes_due.insert(bytes_due.size(), b);
    endfunction

    function automatic void predict_bank_access(input t_bus_op op);
        int unsigned p;
        t_tx_byte    b;
        if (op.cmd == CMD_WRITE) begin
            if (op.first_byte) begin
                shadow_ptr = op.data;
            end else if (shadow_ptr < NUM_REGS) begin
                shadow_bank[shadow_ptr] = op.data;
                shadow_ptr = shadow_ptr + 1'b1;
            end
            return;
        end
        shadow_bank[0] = shadow_temp[15:8];
        shadow_bank[1] = shadow_temp[7:0];
        shadow_bank[2] = shadow_hum[15:8];
        shadow_bank[3] = shadow_hum[7:0];
        if (shadow_ptr >= NUM_REGS) begin
            b.data = ERR_BYTE;
            b.last = 1'b1;
            b.err  = 1'b1;
            expect_byte(b);
            return;
        end
        for (p = 32'(shadow_ptr); p < NUM_REGS; p++) begin
            b.data = shadow_bank[p];
            b.last = (p == NUM_REGS - 1);
            b.err  = 1'b0;
            expect_byte(b);
        end
    endfunction

    // response side: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_stalls && $urandom_range(0, 3) == 0) stall_left = gap_len();
        end
    end

    // response checker and run limit
    always @(posedge i_clk) begin
        t_tx_byte exp_b;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("i2c_target_register_bank verification failed");
            $finish;
        end else if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (bytes_due.size() == 0) begin
                $error("unexpected response: read_data %0h last %0b pointer_error %0b",
                       rsp_if.read_data, rsp_if.last, rsp_if.pointer_error);
                fail_count++;
            end else begin
                exp_b = bytes_due.pop_front();
                if (rsp_if.read_data !== exp_b.data) begin
                    $error("read_data: expected %0h actual %0h", exp_b.data, rsp_if.read_data);
                    fail_count++;
                end
                if (rsp_if.last !== exp_b.last) begin
                    $error("last: expected %0b actual %0b", exp_b.last, rsp_if.last);
                    fail_count++;
                end
                if (rsp_if.pointer_error !== exp_b.err) begin
                    $error("pointer_error: expected %0b actual %0b",
                           exp_b.err, rsp_if.pointer_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_op(input logic cmd, input logic first, input logic [7:0] data);
        t_bus_op op;
        int      gap;
        op.cmd        = cmd;
        op.first_byte = first;
        op.data       = data;
        gap = (req_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid      <= 1'b1;
        req_if.cmd        <= op.cmd;
        req_if.first_byte <= op.first_byte;
        req_if.data_in    <= op.data;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_bank_access(op);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == ADDR_TEMP) shadow_temp = value[CFG_W-1:0];
        else if (addr == ADDR_HUM) shadow_hum = value[CFG_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_directed();
        req_gaps   = 1'b0;
        rsp_stalls = 1'b0;
        send_op(CMD_READ,  1'b0, 8'h00);
        send_op(CMD_WRITE, 1'b1, 8'd4);
        send_op(CMD_WRITE, 1'b0, 8'hFF);
        send_op(CMD_WRITE, 1'b0, 8'h00);
        send_op(CMD_WRITE, 1'b0, 8'hA5);
        send_op(CMD_READ,  1'b0, 8'h00);
        // data written to registers 0..1 is replaced by the sensor mirror
        send_op(CMD_WRITE, 1'b1, 8'd0);
        send_op(CMD_WRITE, 1'b0, 8'h12);
        send_op(CMD_WRITE, 1'b0, 8'h34);
        send_op(CMD_READ,  1'b1, 8'hFF);
        // fill the last register, then overrun the end
        send_op(CMD_WRITE, 1'b1, 8'd15);
        send_op(CMD_WRITE, 1'b0, 8'h5A);
        send_op(CMD_WRITE, 1'b0, 8'h33);
        send_op(CMD_READ,  1'b0, 8'h00);
        send_op(CMD_WRITE, 1'b1, 8'hFF);
        send_op(CMD_READ,  1'b1, 8'hFF);
        send_op(CMD_WRITE, 1'b0, 8'h77);
        send_op(CMD_WRITE, 1'b1, 8'd16);
        send_op(CMD_READ,  1'b0, 8'h55);
        send_op(CMD_WRITE, 1'b1, 8'd15);
        send_op(CMD_READ,  1'b0, 8'hAA);
        send_op(CMD_WRITE, 1'b1, 8'h80);
        send_op(CMD_READ,  1'b0, 8'h00);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        apb_write(ADDR_TEMP, 32'h0000_0000);
        apb_write(ADDR_HUM,  32'hFFFF_FFFF);
        send_op(CMD_WRITE, 1'b1, 8'd0);
        send_op(CMD_READ,  1'b0, 8'h00);
        wait_drained();
        apb_write(ADDR_TEMP, 32'hA5A5_FFFF);
        apb_write(ADDR_HUM,  32'h5A5A_0000);
        send_op(CMD_READ,  1'b0, 8'h00);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int phase;
        int sent;
        int r;
        int n_data;
        logic [7:0] ptr;
        for (phase = 0; phase < 5; phase++) begin
            req_gaps   = (phase != 2);
            rsp_stalls = (phase != 2) && (phase != 4);
            apb_write(ADDR_TEMP, $urandom());
            apb_write(ADDR_HUM,  $urandom());
            sent = 0;
            while (sent < n_items / 5) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    ptr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, NUM_REGS + 1));
                    send_op(CMD_WRITE, 1'b1, ptr);
                    n_data = $urandom_range(0, 6);
                    repeat (n_data) send_op(CMD_WRITE, 1'b0, 8'($urandom_range(0, 255)));
                    sent += 1 + n_data;
                    if ($urandom_range(0, 1) == 0) begin
                        send_op(CMD_READ, 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)));
                        sent++;
                    end
                end else if (r < 90) begin
                    send_op(CMD_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    sent++;
                end else begin
                    send_op(CMD_WRITE, 1'b0, 8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        req_gaps   = 1'b0;
        rsp_stalls = 1'b0;
        hold_left  = 400;
        send_op(CMD_WRITE, 1'b1, 8'd0);
        repeat (12) send_op(CMD_READ, 1'b0, 8'($urandom_range(0, 255)));
        // sender pause until every pending byte has gone out
        wait_drained();
        rsp_stalls = 1'b1;
        send_op(CMD_WRITE, 1'b1, 8'($urandom_range(0, NUM_REGS - 1)));
        repeat (4) send_op(CMD_READ, 1'b0, 8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    initial begin
        fail_count        = 0;
        cycle_count       = 0;
        hold_left         = 0;
        stall_left        = 0;
        req_gaps          = 1'b0;
        rsp_stalls        = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_WRITE;
        req_if.first_byte = 1'b0;
        req_if.data_in    = '0;
        rsp_if.ready      = 1'b0;
        for (int i = 0; i < NUM_REGS; i++) shadow_bank[i] = '0;
        shadow_ptr  = '0;
        shadow_temp = TEMP_RESET;
        shadow_hum  = HUM_RESET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_random_traffic(300);
        test_backpressure();

        if (fail_count == 0) begin
            $display("i2c_target_register_bank verification clean");
        end else begin
            $display("i2c_target_register_bank verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/i2crb_pkg.sv
hdl/i2crb_if.sv
hdl/i2crb_mem.sv
hdl/i2crb_apb.sv
hdl/i2c_target_register_bank.sv
tb/sv/i2c_target_register_bank_tb.sv
